>>> src/assert_macros.svh
// Assertion helper macros for the alignment block checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

>>> src/lsa_pkg.sv
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and constants of the local sequence alignment block.
// ----------------------------------------------------------------------------
package lsa_pkg;
    localparam int MAX_LEN = 32;
    localparam int DIM     = MAX_LEN + 1;
    localparam int LW      = $clog2(MAX_LEN + 1);
    localparam int IW      = $clog2(MAX_LEN);
    localparam int MW      = $clog2(DIM * DIM);
    localparam int PW      = $clog2(2 * MAX_LEN + 1);
    localparam int PIW     = $clog2(2 * MAX_LEN);

    localparam logic [1:0] ACT_A     = 2'd0;
    localparam logic [1:0] ACT_B     = 2'd1;
    localparam logic [1:0] ACT_ALIGN = 2'd2;

    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    localparam logic [1:0] PATH_DIAG = 2'd0;
    localparam logic [1:0] PATH_UP   = 2'd1;
    localparam logic [1:0] PATH_LEFT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FRD, ST_FWAIT, ST_FCALC, ST_TSTART, ST_TRD, ST_TWAIT,
        ST_TCALC, ST_ESTART, ST_ERD, ST_EWAIT, ST_EOUT
    } state_t;

    typedef struct packed {
        logic [7:0] symbol_a;
        logic [7:0] symbol_b;
        logic       gap_in_a;
        logic       gap_in_b;
        logic       is_match;
        logic [7:0] best_score;
        logic [5:0] end_a;
        logic [5:0] end_b;
        logic       empty_res;
        logic       overflow;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] symbol;
    } item_t;
endpackage

>>> src/lsa_if.sv
// ----------------------------------------------------------------------------
// lsa_in_if / lsa_out_if
// Valid/ready channels carrying input items and result beats.
// ----------------------------------------------------------------------------
interface lsa_in_if;
    logic          valid;
    logic          ready;
    lsa_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lsa_out_if;
    logic            valid;
    logic            ready;
    lsa_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/lsa_cell_unit.sv
// ----------------------------------------------------------------------------
// lsa_cell_unit
// Shared score unit: diagonal, up and left candidates and clamped cell value.
// ----------------------------------------------------------------------------
module lsa_cell_unit (
    input  logic [7:0]       sym_a,
    input  logic [7:0]       sym_b,
    input  logic [7:0]       diag,
    input  logic [7:0]       up,
    input  logic [7:0]       left,
    input  logic [2:0]       match_score,
    input  logic signed [3:0] mismatch_score,
    input  logic [3:0]       gap_penalty,
    output logic signed [10:0] d_sum,
    output logic signed [10:0] u_sum,
    output logic [7:0]       cell_val,
    output logic             eq
);
    logic signed [10:0] l_sum;
    logic signed [10:0] r;

    always_comb
    begin
        eq    = (sym_a == sym_b);
        d_sum = $signed({3'b0, diag}) + (eq ? $signed({8'b0, match_score})
                                            : 11'(mismatch_score));
        u_sum = $signed({3'b0, up}) - $signed({7'b0, gap_penalty});
        l_sum = $signed({3'b0, left}) - $signed({7'b0, gap_penalty});
        r = '0;
        if (d_sum > r) r = d_sum;
        if (u_sum > r) r = u_sum;
        if (l_sum > r) r = l_sum;
        cell_val = (r > 11'sd255) ? 8'd255 : r[7:0];
    end
endmodule

>>> src/local_sequence_alignment_top.sv
// ----------------------------------------------------------------------------
// local_sequence_alignment_top
// Smith-Waterman local aligner with linear gap, one shared cell unit.
// ----------------------------------------------------------------------------
// Usage: in_ch carries beats of {action, symbol}. Append beats store a
// symbol into sequence A or B; symbols past MAX_LEN are dropped and flagged
// in the overflow field of the next run. An align beat fills the
// (la+1)x(lb+1) score matrix cell by cell: three neighbour reads through the
// single matrix read port, each a read state and a wait state, then a calc
// state in the cell unit. Traceback takes each step the same way, and the
// path is then replayed column by column through read, wait and output
// states, each column waiting until the previous beat has been taken.
// A zero score gives one empty beat.
// in_ch.ready is low from the align beat until the last result beat has
// been taken. out_ch holds its beat while out_ch.ready is low.
// Reset clears lengths, overflow flag, control state and restores the
// register defaults; the memories need no clearing pass, the boundary row
// and column are read as zero. Config writes (cfg_we, cfg_index, cfg_data)
// must be taken only while idle; the user ensures this, the block does not.
// ----------------------------------------------------------------------------
module local_sequence_alignment_top (
    input  logic       clk,
    input  logic       rst_n,
    lsa_in_if.sink     in_ch,
    lsa_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [3:0] cfg_data
);
    localparam int MAX_LEN = lsa_pkg::MAX_LEN;
    localparam int DIM     = lsa_pkg::DIM;
    localparam int LW      = lsa_pkg::LW;
    localparam int IW      = lsa_pkg::IW;
    localparam int MW      = lsa_pkg::MW;
    localparam int PW      = lsa_pkg::PW;
    localparam int PIW     = lsa_pkg::PIW;

    logic [2:0]        match_reg;
    logic signed [3:0] mism_reg;
    logic [3:0]        gap_reg;

    logic [7:0] seq_a [MAX_LEN];
    logic [7:0] seq_b [MAX_LEN];
    logic [7:0] mat [DIM*DIM];
    logic [1:0] path [2*MAX_LEN];

    logic [LW-1:0] len_a_reg, len_b_reg;
    logic          ovf_reg;
    lsa_pkg::state_t state_reg, state_next;
    logic [LW-1:0] i_reg, i_next, j_reg, j_next;
    logic [LW-1:0] bi_reg, bi_next, bj_reg, bj_next;
    logic [7:0]    best_reg, best_next;
    logic [PW-1:0] n_reg, n_next, k_reg, k_next;
    logic [1:0]    rcnt_reg, rcnt_next;
    logic [7:0]    cur_reg, cur_next;
    logic [7:0]    d_reg, u_reg, l_reg, sa_reg, sb_reg;
    logic [1:0]    code_reg;
    logic          out_valid_reg, out_valid_next;
    lsa_pkg::result_t out_reg, out_next;

    logic          mwe;
    logic [MW-1:0] mwaddr, mraddr;
    logic [7:0]    mwdata, mrdata;
    logic          pwe;
    logic [PIW-1:0] pwaddr, praddr;
    logic [1:0]    pwdata;
    logic [IW-1:0] ra_addr, rb_addr;

    logic signed [10:0] d_sum, u_sum;
    logic [7:0] cell_val;
    logic       eq;

    lsa_cell_unit u_cell (
        .sym_a(sa_reg), .sym_b(sb_reg), .diag(d_reg), .up(u_reg), .left(l_reg),
        .match_score(match_reg), .mismatch_score(mism_reg), .gap_penalty(gap_reg),
        .d_sum(d_sum), .u_sum(u_sum), .cell_val(cell_val), .eq(eq)
    );

    function automatic logic [MW-1:0] maddr(input logic [LW-1:0] r, input logic [LW-1:0] c);
        maddr = MW'(r * DIM) + MW'(c);
    endfunction

    wire in_acc = in_ch.valid && in_ch.ready;
    assign in_ch.ready  = (state_reg == lsa_pkg::ST_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // memories: three matrix reads are sequenced through one read port
    always_ff @(posedge clk)
    begin
        if (mwe) mat[mwaddr] <= mwdata;
        mrdata <= mat[mraddr];
        if (pwe) path[pwaddr] <= pwdata;
        code_reg <= path[praddr];
        if (in_acc && in_ch.data.action == lsa_pkg::ACT_A && len_a_reg < LW'(MAX_LEN))
            seq_a[len_a_reg[IW-1:0]] <= in_ch.data.symbol;
        if (in_acc && in_ch.data.action == lsa_pkg::ACT_B && len_b_reg < LW'(MAX_LEN))
            seq_b[len_b_reg[IW-1:0]] <= in_ch.data.symbol;
        sa_reg <= seq_a[ra_addr];
        sb_reg <= seq_b[rb_addr];
    end

    // neighbour capture; zero at the boundary
    always_ff @(posedge clk)
    begin
        if (state_reg == lsa_pkg::ST_FWAIT || state_reg == lsa_pkg::ST_TWAIT)
        begin
            unique case (rcnt_reg)
                2'd0: d_reg <= (i_reg == LW'(1) || j_reg == LW'(1)) ? 8'd0 : mrdata;
                2'd1: u_reg <= (i_reg == LW'(1)) ? 8'd0 : mrdata;
                default: l_reg <= (j_reg == LW'(1)) ? 8'd0 : mrdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 3'd1;
            mism_reg  <= -4'sd1;
            gap_reg   <= 4'd2;
            len_a_reg <= '0;
            len_b_reg <= '0;
            ovf_reg   <= 1'b0;
            state_reg <= lsa_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            i_reg <= '0; j_reg <= '0; bi_reg <= '0; bj_reg <= '0;
            best_reg <= '0; n_reg <= '0; k_reg <= '0; rcnt_reg <= '0; cur_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    lsa_pkg::REG_MATCH:    match_reg <= cfg_data[2:0];
                    lsa_pkg::REG_MISMATCH: mism_reg  <= cfg_data;
                    lsa_pkg::REG_GAP:      gap_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (in_acc && in_ch.data.action == lsa_pkg::ACT_A)
            begin
                if (len_a_reg < LW'(MAX_LEN)) len_a_reg <= len_a_reg + 1'b1;
                else ovf_reg <= 1'b1;
            end
            if (in_acc && in_ch.data.action == lsa_pkg::ACT_B)
            begin
                if (len_b_reg < LW'(MAX_LEN)) len_b_reg <= len_b_reg + 1'b1;
                else ovf_reg <= 1'b1;
            end
            if (out_valid_reg && out_ch.ready && out_reg.last)
            begin
                len_a_reg <= '0;
                len_b_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg <= i_next; j_reg <= j_next; bi_reg <= bi_next; bj_reg <= bj_next;
            best_reg <= best_next; n_reg <= n_next; k_reg <= k_next;
            rcnt_reg <= rcnt_next; cur_reg <= cur_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        i_next = i_reg; j_next = j_reg; bi_next = bi_reg; bj_next = bj_reg;
        best_next = best_reg; n_next = n_reg; k_next = k_reg;
        rcnt_next = rcnt_reg; cur_next = cur_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        mwe = 1'b0; mwaddr = maddr(i_reg, j_reg); mwdata = cell_val;
        pwe = 1'b0; pwaddr = n_reg[PIW-1:0]; pwdata = lsa_pkg::PATH_DIAG;
        praddr = PIW'(n_reg - 1'b1 - k_reg);
        ra_addr = IW'(i_reg - 1'b1);
        rb_addr = IW'(j_reg - 1'b1);
        unique case (rcnt_reg)
            2'd0:    mraddr = maddr(i_reg - 1'b1, j_reg - 1'b1);
            2'd1:    mraddr = maddr(i_reg - 1'b1, j_reg);
            2'd2:    mraddr = maddr(i_reg, j_reg - 1'b1);
            default: mraddr = maddr(i_reg, j_reg);
        endcase
        if (out_valid_reg && out_ch.ready) out_valid_next = 1'b0;

        unique case (state_reg)
            lsa_pkg::ST_IDLE:
            begin
                if (in_acc && in_ch.data.action == lsa_pkg::ACT_ALIGN)
                begin
                    best_next = '0; bi_next = '0; bj_next = '0; n_next = '0;
                    i_next = LW'(1); j_next = LW'(1); rcnt_next = '0;
                    if (len_a_reg == 0 || len_b_reg == 0) state_next = lsa_pkg::ST_TSTART;
                    else state_next = lsa_pkg::ST_FRD;
                end
            end
            lsa_pkg::ST_FRD, lsa_pkg::ST_TRD:
            begin
                state_next = (state_reg == lsa_pkg::ST_FRD) ? lsa_pkg::ST_FWAIT
                                                           : lsa_pkg::ST_TWAIT;
            end
            lsa_pkg::ST_FWAIT, lsa_pkg::ST_TWAIT:
            begin
                if (rcnt_reg == 2'd2)
                begin
                    rcnt_next = '0;
                    state_next = (state_reg == lsa_pkg::ST_FWAIT) ? lsa_pkg::ST_FCALC
                                                                 : lsa_pkg::ST_TCALC;
                end
                else
                begin
                    rcnt_next = rcnt_reg + 1'b1;
                    state_next = (state_reg == lsa_pkg::ST_FWAIT) ? lsa_pkg::ST_FRD
                                                                 : lsa_pkg::ST_TRD;
                end
            end
            lsa_pkg::ST_FCALC:
            begin
                mwe = 1'b1;
                if (cell_val > best_reg)
                begin
                    best_next = cell_val; bi_next = i_reg; bj_next = j_reg;
                end
                state_next = lsa_pkg::ST_FRD;
                if (j_reg == len_b_reg)
                begin
                    j_next = LW'(1);
                    i_next = i_reg + 1'b1;
                    if (i_reg == len_a_reg) state_next = lsa_pkg::ST_TSTART;
                end
                else j_next = j_reg + 1'b1;
            end
            lsa_pkg::ST_TSTART:
            begin
                if (best_reg == 0)
                begin
                    if (!out_valid_reg)
                    begin
                        out_next = '0;
                        out_next.empty_res = 1'b1;
                        out_next.last = 1'b1;
                        out_next.overflow = ovf_reg;
                        out_valid_next = 1'b1;
                        state_next = lsa_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    i_next = bi_reg; j_next = bj_reg; rcnt_next = '0;
                    cur_next = best_reg;
                    state_next = lsa_pkg::ST_TRD;
                end
            end
            lsa_pkg::ST_TCALC:
            begin
                pwe = 1'b1;
                n_next = n_reg + 1'b1;
                if ($signed({3'b0, cur_reg}) == d_sum)
                begin
                    pwdata = lsa_pkg::PATH_DIAG;
                    i_next = i_reg - 1'b1; j_next = j_reg - 1'b1; cur_next = d_reg;
                end
                else if ($signed({3'b0, cur_reg}) == u_sum)
                begin
                    pwdata = lsa_pkg::PATH_UP;
                    i_next = i_reg - 1'b1; cur_next = u_reg;
                end
                else
                begin
                    pwdata = lsa_pkg::PATH_LEFT;
                    j_next = j_reg - 1'b1; cur_next = l_reg;
                end
                state_next = lsa_pkg::ST_TRD;
                if (i_next == 0 || j_next == 0 || cur_next == 0 ||
                    n_next == PW'(2 * MAX_LEN))
                    state_next = lsa_pkg::ST_ESTART;
            end
            lsa_pkg::ST_ESTART:
            begin
                k_next = '0;
                state_next = lsa_pkg::ST_ERD;
            end
            lsa_pkg::ST_ERD:
            begin
                ra_addr = i_reg[IW-1:0];
                rb_addr = j_reg[IW-1:0];
                state_next = lsa_pkg::ST_EWAIT;
            end
            lsa_pkg::ST_EWAIT:
            begin
                ra_addr = i_reg[IW-1:0];
                rb_addr = j_reg[IW-1:0];
                state_next = lsa_pkg::ST_EOUT;
            end
            lsa_pkg::ST_EOUT:
            begin
                ra_addr = i_reg[IW-1:0];
                rb_addr = j_reg[IW-1:0];
                if (!out_valid_reg)
                begin
                    out_next = '0;
                    out_next.best_score = best_reg;
                    out_next.end_a = 6'(bi_reg);
                    out_next.end_b = 6'(bj_reg);
                    out_next.overflow = ovf_reg;
                    out_next.last = (k_reg == n_reg - 1'b1);
                    unique case (code_reg)
                        lsa_pkg::PATH_DIAG:
                        begin
                            out_next.symbol_a = sa_reg; out_next.symbol_b = sb_reg;
                            out_next.is_match = eq;
                            i_next = i_reg + 1'b1; j_next = j_reg + 1'b1;
                        end
                        lsa_pkg::PATH_UP:
                        begin
                            out_next.symbol_a = sa_reg; out_next.gap_in_b = 1'b1;
                            i_next = i_reg + 1'b1;
                        end
                        default:
                        begin
                            out_next.symbol_b = sb_reg; out_next.gap_in_a = 1'b1;
                            j_next = j_reg + 1'b1;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    k_next = k_reg + 1'b1;
                    state_next = out_next.last ? lsa_pkg::ST_IDLE : lsa_pkg::ST_ERD;
                end
            end
            default: state_next = lsa_pkg::ST_IDLE;
        endcase
    end
endmodule

>>> src/lsa_checker.sv
// ----------------------------------------------------------------------------
// lsa_checker
// Port-level checks of the alignment block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lsa_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_last,
    input logic out_empty
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "beat dropped")
    `ASSERT_IMPL(a_busy, clk, rst_n, out_valid, !in_ready, "ready while results pending")
    `ASSERT_IMPL(a_empty_last, clk, rst_n, out_valid && out_empty, out_last,
                 "empty result not last")
    `ASSERT_NEXT(a_ready_after, clk, rst_n, out_valid && out_ready && out_last, !out_valid,
                 "beat after last")
endmodule

bind local_sequence_alignment_top lsa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_last(out_ch.data.last), .out_empty(out_ch.data.empty_res)
);

>>> sim/local_sequence_alignment_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_sequence_alignment_top_tb
// Drives symbol appends and align beats into the Smith-Waterman aligner under
// several score settings and idle patterns, predicts every alignment column
// with an independent scoring and traceback model, and checks each result
// beat field by field in order.
// ----------------------------------------------------------------------------
module local_sequence_alignment_top_tb;
    localparam logic [1:0] ACT_NOP = 2'd3;

    class align_scoreboard;
        logic [7:0] seq_a [lsa_pkg::MAX_LEN];
        logic [7:0] seq_b [lsa_pkg::MAX_LEN];
        int         len_a;
        int         len_b;
        bit         dropped;
        logic [2:0] match_val;
        logic [3:0] mismatch_val;
        logic [3:0] gap_val;
        int         h [lsa_pkg::DIM][lsa_pkg::DIM];
        lsa_pkg::result_t pending [$];
        int         errors;
        int         runs;
        int         columns;

        function new();
            len_a = 0;
            len_b = 0;
            dropped = 0;
            match_val = 3'd1;
            mismatch_val = 4'hF;
            gap_val = 4'd2;
            errors = 0;
            runs = 0;
            columns = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [3:0] val);
            if (idx == lsa_pkg::REG_MATCH) match_val = val[2:0];
            else if (idx == lsa_pkg::REG_MISMATCH) mismatch_val = val;
            else if (idx == lsa_pkg::REG_GAP) gap_val = val;
        endfunction

        function int pair(int i, int j);
            if (seq_a[i-1] == seq_b[j-1]) return int'(match_val);
            return int'($signed(mismatch_val));
        endfunction

        function void run_alignment();
            int best, bi, bj, g, i, j, d, u, l, r, n, k, c;
            logic [1:0] steps [2*lsa_pkg::MAX_LEN];
            lsa_pkg::result_t res;
            best = 0; bi = 0; bj = 0; n = 0;
            g = int'(gap_val);
            for (i = 0; i < lsa_pkg::DIM; i++)
                for (j = 0; j < lsa_pkg::DIM; j++)
                    h[i][j] = 0;
            for (i = 1; i <= len_a; i++)
                for (j = 1; j <= len_b; j++)
                begin
                    d = h[i-1][j-1] + pair(i, j);
                    u = h[i-1][j] - g;
                    l = h[i][j-1] - g;
                    r = 0;
                    if (d > r) r = d;
                    if (u > r) r = u;
                    if (l > r) r = l;
                    if (r > 255) r = 255;
                    h[i][j] = r;
                    if (r > best)
                    begin
                        best = r; bi = i; bj = j;
                    end
                end
            runs++;
            res = '0;
            res.overflow = dropped;
            if (best == 0)
            begin
                res.empty_res = 1'b1;
                res.last = 1'b1;
                pending.push_back(res);
                return;
            end
            i = bi; j = bj;
            while (i > 0 && j > 0 && h[i][j] > 0 && n < 2 * lsa_pkg::MAX_LEN)
            begin
                c = h[i][j];
                if (c == h[i-1][j-1] + pair(i, j))
                begin
                    steps[n++] = lsa_pkg::PATH_DIAG; i--; j--;
                end
                else if (c == h[i-1][j] - g)
                begin
                    steps[n++] = lsa_pkg::PATH_UP; i--;
                end
                else
                begin
                    steps[n++] = lsa_pkg::PATH_LEFT; j--;
                end
            end
            for (k = 0; k < n; k++)
            begin
                res = '0;
                res.best_score = best[7:0];
                res.end_a = bi[5:0];
                res.end_b = bj[5:0];
                res.overflow = dropped;
                res.last = (k == n - 1);
                if (steps[n-1-k] == lsa_pkg::PATH_DIAG)
                begin
                    res.symbol_a = seq_a[i];
                    res.symbol_b = seq_b[j];
                    res.is_match = (seq_a[i] == seq_b[j]);
                    i++; j++;
                end
                else if (steps[n-1-k] == lsa_pkg::PATH_UP)
                begin
                    res.symbol_a = seq_a[i];
                    res.gap_in_b = 1'b1;
                    i++;
                end
                else
                begin
                    res.symbol_b = seq_b[j];
                    res.gap_in_a = 1'b1;
                    j++;
                end
                pending.push_back(res);
            end
        endfunction

        function void note_item(lsa_pkg::item_t it);
            if (it.action == lsa_pkg::ACT_A)
            begin
                if (len_a < lsa_pkg::MAX_LEN) seq_a[len_a++] = it.symbol;
                else dropped = 1;
            end
            else if (it.action == lsa_pkg::ACT_B)
            begin
                if (len_b < lsa_pkg::MAX_LEN) seq_b[len_b++] = it.symbol;
                else dropped = 1;
            end
            else if (it.action == lsa_pkg::ACT_ALIGN)
            begin
                run_alignment();
                len_a = 0;
                len_b = 0;
                dropped = 0;
            end
        endfunction

        function void cmp(string name, int exp_v, int act_v);
            if (exp_v != act_v)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(lsa_pkg::result_t got);
            lsa_pkg::result_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result beat %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            columns++;
            cmp("symbol_a", e.symbol_a, got.symbol_a);
            cmp("symbol_b", e.symbol_b, got.symbol_b);
            cmp("gap_in_a", e.gap_in_a, got.gap_in_a);
            cmp("gap_in_b", e.gap_in_b, got.gap_in_b);
            cmp("is_match", e.is_match, got.is_match);
            cmp("best_score", e.best_score, got.best_score);
            cmp("end_a", e.end_a, got.end_a);
            cmp("end_b", e.end_b, got.end_b);
            cmp("empty_res", e.empty_res, got.empty_res);
            cmp("overflow", e.overflow, got.overflow);
            cmp("last", e.last, got.last);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;
    int         src_idle;
    int         snk_idle;
    bit         hold_off;
    int         quiet;
    int         sent;
    align_scoreboard sb;

    lsa_in_if  in_ch ();
    lsa_out_if out_ch ();

    local_sequence_alignment_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = lsa_pkg::REG_MATCH;
        cfg_data = 4'd0;
        src_idle = 0;
        snk_idle = 0;
        hold_off = 0;
        sb = new();
    end

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
        out_ch.ready <= !hold_off && ($urandom_range(99) >= snk_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > 30000)
        begin
            $display("local_sequence_alignment_top verification failed");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] act, logic [7:0] sym);
        lsa_pkg::item_t it;
        it.action = act;
        it.symbol = sym;
        while ($urandom_range(99) < src_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_item(it);
        if (act != ACT_NOP) sent++;
    endtask

    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    function automatic logic [7:0] pick_symbol();
        if ($urandom_range(99) < 70) return 8'($urandom_range(3));
        return 8'($urandom_range(255));
    endfunction

    task automatic random_run();
        int la, lb;
        la = ($urandom_range(99) < 8) ? $urandom_range(28, 34) : $urandom_range(0, 7);
        lb = ($urandom_range(99) < 8) ? $urandom_range(28, 34) : $urandom_range(0, 7);
        while (la + lb > 0)
        begin
            if ($urandom_range(99) < 4) send_item(ACT_NOP, 8'($urandom_range(255)));
            if (lb == 0 || (la > 0 && $urandom_range(1)))
            begin
                send_item(lsa_pkg::ACT_A, pick_symbol());
                la--;
            end
            else
            begin
                send_item(lsa_pkg::ACT_B, pick_symbol());
                lb--;
            end
        end
        send_item(lsa_pkg::ACT_ALIGN, 8'($urandom_range(255)));
    endtask

    initial
    begin
        int p, k, target;
        logic [2:0] m_set [5];
        logic [3:0] x_set [5];
        logic [3:0] g_set [5];
        m_set = '{3'd7, 3'd0, 3'd3, 3'd7, 3'd2};
        x_set = '{4'h8, 4'h0, 4'hE, 4'h0, 4'hC};
        g_set = '{4'd8, 4'd0, 4'd1, 4'd0, 4'd3};
        sent = 0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(lsa_pkg::ACT_ALIGN, 8'hFF);
        send_item(lsa_pkg::ACT_A, 8'h00);
        send_item(lsa_pkg::ACT_ALIGN, 8'h00);
        send_item(lsa_pkg::ACT_A, 8'hFF);
        send_item(lsa_pkg::ACT_A, 8'h00);
        send_item(lsa_pkg::ACT_B, 8'hFF);
        send_item(lsa_pkg::ACT_B, 8'h00);
        send_item(ACT_NOP, 8'hAA);
        send_item(lsa_pkg::ACT_ALIGN, 8'h55);
        send_item(lsa_pkg::ACT_A, 8'h12);
        send_item(lsa_pkg::ACT_B, 8'h34);
        send_item(lsa_pkg::ACT_ALIGN, 8'h00);
        for (k = 0; k < 33; k++) send_item(lsa_pkg::ACT_A, 8'(k));
        send_item(lsa_pkg::ACT_B, 8'd5);
        send_item(lsa_pkg::ACT_ALIGN, 8'h00);
        settle();

        for (p = 0; p < 5; p++)
        begin
            write_reg(lsa_pkg::REG_MATCH, {1'b0, m_set[p]});
            write_reg(lsa_pkg::REG_MISMATCH, x_set[p]);
            write_reg(lsa_pkg::REG_GAP, g_set[p]);
            src_idle = (p % 3 == 0) ? 33 : (p % 3 == 1) ? 71 : 0;
            snk_idle = (p % 3 == 0) ? 71 : (p % 3 == 1) ? 33 : 0;
            if (p == 3)
            begin
                for (k = 0; k < 32; k++) send_item(lsa_pkg::ACT_A, 8'h7);
                for (k = 0; k < 32; k++) send_item(lsa_pkg::ACT_B, 8'h7);
                send_item(lsa_pkg::ACT_ALIGN, 8'h0);
            end
            if (p == 0)
                fork
                    begin
                        hold_off = 1;
                        repeat (400) @(posedge clk);
                        hold_off = 0;
                    end
                join_none
            target = sent + 70;
            while (sent < target) random_run();
            settle();
        end

        $display("covered %0d input beats, %0d align runs, %0d result beats",
                 sent, sb.runs, sb.columns);
        $display("score settings: default plus five register sets incl. extremes");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("local_sequence_alignment_top verification clean");
        else
            $display("local_sequence_alignment_top verification failed");
        $finish;
    end
endmodule
